[design/ahtt_pkg.sv]
`default_nettype none

package ahtt_pkg;

  // field widths
  localparam int AGE_W     = 4;
  localparam int WORD_W    = 40;
  localparam int ENTRY_W   = 48;
  localparam int RATIO_W   = 7;
  localparam int THR_W     = 4;
  localparam int PROD_W    = WORD_W + RATIO_W;
  localparam int CFG_W     = RATIO_W;
  localparam int CFG_IDX_W = 1;

  // defaults and constants
  localparam int NUM_AGES_DEF = 16;
  localparam int PERCENT      = 100;
  localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(50);
  localparam logic [THR_W-1:0]   MAX_RST   = THR_W'(15);

  // divide by 100 as a shift by 2, then multiply by ceil(2^RECIP_SH / 25)
  // exact for every product shifted down to at most 45 bits
  localparam int RECIP_SH = 50;
  localparam int RECIP_W  = 46;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(PERCENT / 4 - 1)) / 64'(PERCENT / 4));

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 1'b1;

  // item kinds
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_DIV,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[design/age_histogram_tenure_threshold.sv]
`default_nettype none
// Clear: clears all entry valid bits. Add: table read, then saturating write back.
// Compute: capacity*ratio is formed and registered, then multiply-accumulate steps by the
//   reciprocal of 100 (ST_DIV), a table read and an accumulate per entry walked (at most
//   NUM_AGES-1), and a load of the result register, held off while an earlier result is stalled.
// One transaction in work at a time: input stall stays high until it is done.
// Reset (synchronous, rst_n low): target_ratio 50, max_threshold 15, entry valid bits clear.

module age_histogram_tenure_threshold #(
  parameter int NUM_AGES = ahtt_pkg::NUM_AGES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_action,
  input  wire logic [ahtt_pkg::AGE_W-1:0]       in_age,
  input  wire logic [ahtt_pkg::WORD_W-1:0]      in_word_count,
  input  wire logic [ahtt_pkg::WORD_W-1:0]      in_survivor_capacity,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [ahtt_pkg::THR_W-1:0]       out_threshold,
  output logic      [ahtt_pkg::WORD_W-1:0]      out_desired_size,
  // configuration port
  input  wire logic                             cfg_we,
  input  wire logic [ahtt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ahtt_pkg::CFG_W-1:0]       cfg_wdata
);

  import ahtt_pkg::*;

  localparam int AW        = (NUM_AGES > 1) ? $clog2(NUM_AGES) : 1;
  localparam int FW        = $clog2(NUM_AGES + 1);
  localparam int TOT_W     = ENTRY_W + AW;
  localparam int X_W       = PROD_W - 2;
  localparam int HALF_W    = (X_W + 1) / 2;
  localparam int PP_W      = 2 * HALF_W;
  localparam int ACC_W     = 2 * PP_W;
  localparam int MUL_STEPS = 4;
  localparam int CNT_W     = 2;

  // control state
  state_t               state_r, state_nxt;
  logic [NUM_AGES-1:0]  valid_r, valid_nxt;
  logic [RATIO_W-1:0]   ratio_r, ratio_nxt;
  logic [THR_W-1:0]     max_thr_r, max_thr_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // datapath registers
  logic [AW-1:0]        add_addr_r, add_addr_nxt;
  logic [WORD_W-1:0]    add_words_r, add_words_nxt;
  logic [X_W-1:0]       div_r, div_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [TOT_W-1:0]     total_r, total_nxt;
  logic [FW-1:0]        found_r, found_nxt;
  logic                 rd_valid_r, rd_valid_nxt;
  logic [THR_W-1:0]     out_thr_r, out_thr_nxt;
  logic [WORD_W-1:0]    out_des_r, out_des_nxt;

  // table port signals
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  // helpers
  logic                 in_acc;
  logic                 out_free;
  logic                 age_ok;
  logic [RATIO_W-1:0]   ratio_c;
  logic [PROD_W-1:0]    prod;
  logic [HALF_W-1:0]    mul_a;
  logic [HALF_W-1:0]    mul_b;
  logic [PP_W-1:0]      pp;
  logic [ACC_W-1:0]     pp_ext;
  logic [ACC_W-1:0]     pp_sh;
  logic [WORD_W-1:0]    desired;
  logic [ENTRY_W-1:0]   old_entry;
  logic [ENTRY_W:0]     add_sum;
  logic [ENTRY_W-1:0]   walk_entry;
  logic [TOT_W-1:0]     tot_sum;
  logic                 exceed;

  ahtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_AGES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign age_ok    = (32'(in_age) < NUM_AGES);
  assign ratio_c   = (ratio_r > RATIO_W'(PERCENT)) ? RATIO_W'(PERCENT) : ratio_r;
  assign prod      = PROD_W'(in_survivor_capacity) * PROD_W'(ratio_c);

  // one partial product of the reciprocal multiply per cycle
  assign mul_a   = cnt_r[1] ? HALF_W'(div_r[X_W-1:HALF_W]) : div_r[HALF_W-1:0];
  assign mul_b   = cnt_r[0] ? HALF_W'(RECIP_M[RECIP_W-1:HALF_W]) : RECIP_M[HALF_W-1:0];
  assign pp      = PP_W'(mul_a) * PP_W'(mul_b);
  assign pp_ext  = ACC_W'(pp);
  assign pp_sh   = (cnt_r == CNT_W'(0)) ? pp_ext :
                   (cnt_r == CNT_W'(MUL_STEPS - 1)) ? (pp_ext << PP_W) : (pp_ext << HALF_W);
  assign desired = acc_r[RECIP_SH +: WORD_W];

  // saturating add for an add transaction
  assign old_entry = rd_valid_r ? ram_rdata : '0;
  assign add_sum   = (ENTRY_W+1)'(old_entry) + (ENTRY_W+1)'(add_words_r);

  // running total over the walked entries
  assign walk_entry = rd_valid_r ? ram_rdata : '0;
  assign tot_sum    = total_r + TOT_W'(walk_entry);
  assign exceed     = (tot_sum > TOT_W'(desired));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_t'(in_action))
            ACT_ADD: begin
              if (age_ok) begin
                state_nxt = ST_ADD_WR;
              end
            end
            ACT_COMPUTE: state_nxt = ST_DIV;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR: state_nxt = ST_IDLE;
      ST_DIV: begin
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_RD: state_nxt = ST_WALK_ACC;
      ST_WALK_ACC: begin
        if (exceed || (idx_r == AW'(NUM_AGES - 1))) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    valid_nxt     = valid_r;
    ratio_nxt     = ratio_r;
    max_thr_nxt   = max_thr_r;
    out_valid_nxt = out_valid_r;
    add_addr_nxt  = add_addr_r;
    add_words_nxt = add_words_r;
    div_nxt       = div_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    found_nxt     = found_r;
    rd_valid_nxt  = rd_valid_r;
    out_thr_nxt   = out_thr_r;
    out_des_nxt   = out_des_r;
    ram_we        = 1'b0;
    ram_waddr     = add_addr_r;
    ram_wdata     = add_sum[ENTRY_W] ? {ENTRY_W{1'b1}} : add_sum[ENTRY_W-1:0];
    ram_raddr     = AW'(in_age);

    // configuration writes
    if (cfg_we) begin
      if (cfg_index == CFG_RATIO) begin
        ratio_nxt = cfg_wdata[RATIO_W-1:0];
      end else if (cfg_index == CFG_MAX) begin
        max_thr_nxt = cfg_wdata[THR_W-1:0];
      end
    end

    // result register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = AW'(in_age);
        if (in_acc) begin
          case (action_t'(in_action))
            ACT_CLEAR: valid_nxt = '0;
            ACT_ADD: begin
              add_addr_nxt  = AW'(in_age);
              add_words_nxt = in_word_count;
              rd_valid_nxt  = valid_r[AW'(in_age)];
            end
            ACT_COMPUTE: begin
              div_nxt = X_W'(prod >> 2);
              acc_nxt = '0;
              cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_WR: begin
        ram_we               = 1'b1;
        valid_nxt[add_addr_r] = 1'b1;
      end
      ST_DIV: begin
        acc_nxt   = acc_r + pp_sh;
        cnt_nxt   = cnt_r + CNT_W'(1);
        idx_nxt   = AW'(1);
        total_nxt = '0;
      end
      ST_WALK_RD: begin
        ram_raddr    = idx_r;
        rd_valid_nxt = valid_r[idx_r];
      end
      ST_WALK_ACC: begin
        total_nxt = tot_sum;
        idx_nxt   = idx_r + AW'(1);
        if (exceed) begin
          found_nxt = FW'(idx_r);
        end else begin
          found_nxt = FW'(NUM_AGES);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_thr_nxt   = (32'(found_r) > 32'(max_thr_r)) ? max_thr_r : THR_W'(found_r);
          out_des_nxt   = desired;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      ratio_r     <= RATIO_RST;
      max_thr_r   <= MAX_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      ratio_r     <= ratio_nxt;
      max_thr_r   <= max_thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    add_addr_r  <= add_addr_nxt;
    add_words_r <= add_words_nxt;
    div_r       <= div_nxt;
    acc_r       <= acc_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    total_r     <= total_nxt;
    found_r     <= found_nxt;
    rd_valid_r  <= rd_valid_nxt;
    out_thr_r   <= out_thr_nxt;
    out_des_r   <= out_des_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_threshold    = out_thr_r;
  assign out_desired_size = out_des_r;

endmodule

`default_nettype wire

[design/ahtt_ram.sv]
`default_nettype none

module ahtt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[verif/ahtt_tenure_checker.sv]
`timescale 1ns / 1ps

module ahtt_tenure_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [ahtt_pkg::AGE_W-1:0]       in_age,
  input  logic [ahtt_pkg::WORD_W-1:0]      in_word_count,
  input  logic [ahtt_pkg::WORD_W-1:0]      in_survivor_capacity,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [ahtt_pkg::THR_W-1:0]       out_threshold,
  input  logic [ahtt_pkg::WORD_W-1:0]      out_desired_size,
  input  logic                             cfg_we,
  input  logic [ahtt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ahtt_pkg::CFG_W-1:0]       cfg_wdata,
  output int unsigned                      fail_count,
  output int unsigned                      pending
);
  import ahtt_pkg::*;

  localparam int NUM_AGES = NUM_AGES_DEF;
  localparam longint unsigned ENTRY_MAX = (64'd1 << ENTRY_W) - 64'd1;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [WORD_W-1:0] desired;
  } tenure_t;

  // shadow of the block state
  logic [ENTRY_W-1:0] hist_words [NUM_AGES];
  logic [RATIO_W-1:0] ratio_reg;
  logic [THR_W-1:0]   max_reg;

  tenure_t           due_q [$];
  tenure_t           want;
  longint unsigned   sum;
  int unsigned       errors = 0;

  // threshold age and desired survivor size for one compute transaction
  function automatic tenure_t tenure_for(input logic [WORD_W-1:0] capacity);
    tenure_t         res;
    longint unsigned ratio_eff;
    longint unsigned desired;
    longint unsigned running;
    int              found;
    // ratios above one hundred percent act as one hundred
    ratio_eff = (ratio_reg > PERCENT) ? PERCENT : ratio_reg;
    desired = (64'(capacity) * ratio_eff) / 64'(PERCENT);
    running = 0;
    found = NUM_AGES;
    // age 0 never counts toward the running total
    for (int a = 1; a < NUM_AGES; a++) begin
      running += 64'(hist_words[a]);
      if (found == NUM_AGES && running > desired) found = a;
    end
    if (found > max_reg) found = max_reg;
    res.threshold = THR_W'(found);
    res.desired = WORD_W'(desired);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AGES; i++) hist_words[i] = '0;
      ratio_reg = RATIO_RST;
      max_reg = MAX_RST;
      due_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_RATIO) ratio_reg = cfg_wdata[RATIO_W-1:0];
        else if (cfg_index == CFG_MAX) max_reg = cfg_wdata[THR_W-1:0];
      end
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got threshold %0d desired %0d",
                   $time, out_threshold, out_desired_size);
        end else begin
          want = due_q.pop_front();
          if (out_threshold !== want.threshold) begin
            errors++;
            $display("%0t: threshold mismatch, expected %0d, got %0d",
                     $time, want.threshold, out_threshold);
          end
          if (out_desired_size !== want.desired) begin
            errors++;
            $display("%0t: desired_size mismatch, expected %0d, got %0d",
                     $time, want.desired, out_desired_size);
          end
        end
      end
      // input transaction updates the shadow table
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_CLEAR: begin
            for (int i = 0; i < NUM_AGES; i++) hist_words[i] = '0;
          end
          ACT_ADD: begin
            // ages past the table are dropped, entries saturate
            if (in_age < NUM_AGES) begin
              sum = 64'(hist_words[in_age]) + 64'(in_word_count);
              if (sum > ENTRY_MAX) sum = ENTRY_MAX;
              hist_words[in_age] = ENTRY_W'(sum);
            end
          end
          ACT_COMPUTE: begin
            due_q.push_back(tenure_for(in_survivor_capacity));
          end
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending <= due_q.size();
  end

endmodule

[verif/age_histogram_tenure_threshold_tb.sv]
`timescale 1ns / 1ps

module age_histogram_tenure_threshold_tb;
  import ahtt_pkg::*;

  localparam int NUM_AGES = NUM_AGES_DEF;
  localparam int unsigned MAX_CYCLES = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] WORD_MAX = '1;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_action;
  logic [AGE_W-1:0]      in_age;
  logic [WORD_W-1:0]     in_word_count;
  logic [WORD_W-1:0]     in_survivor_capacity;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [THR_W-1:0]      out_threshold;
  logic [WORD_W-1:0]     out_desired_size;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  int unsigned           fail_count;
  int unsigned           pending;

  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_count = 0;
  bit          steady = 1'b0;

  // receiver pacing state
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  int unsigned rx_pick;

  age_histogram_tenure_threshold dut (.*);

  ahtt_tenure_checker checker_i (.*);

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result-side stalls: short bursts, a few long ones, calm stretches, one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      holds_done = hold_count;
    end else begin
      if (holds_done != hold_count) begin
        holds_done = hold_count;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm_left != 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 4) calm_left = $urandom_range(100, 300);
        else if (rx_pick < 10) stall_left = $urandom_range(8, 40);
        else if (rx_pick < 35) stall_left = $urandom_range(1, 3);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand40();
    return {8'($urandom_range(0, 255)), 32'($urandom())};
  endfunction

  // capacities mostly small, some full width
  function automatic logic [WORD_W-1:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return WORD_W'($urandom_range(0, 3));
    if (r < 40) return WORD_W'($urandom_range(0, 5000));
    if (r < 70) return WORD_W'($urandom_range(0, 24'hFFFFFF));
    if (r < 95) return rand40();
    return WORD_MAX;
  endfunction

  // word counts sized against the capacity so thresholds land across the table
  function automatic logic [WORD_W-1:0] words_for(input logic [WORD_W-1:0] cap);
    if ($urandom_range(0, 9) == 0) return rand40();
    return (cap >> $urandom_range(1, 6)) + WORD_W'($urandom_range(0, 2));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // offer one transaction and hold it until accepted
  task automatic put_item(input logic [1:0] act, input logic [AGE_W-1:0] age,
                          input logic [WORD_W-1:0] words, input logic [WORD_W-1:0] cap);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_age <= age;
    in_word_count <= words;
    in_survivor_capacity <= cap;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // stop sending until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [RATIO_W-1:0] ratio, input logic [THR_W-1:0] max_age);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RATIO;
    cfg_wdata <= ratio;
    @(posedge clk);
    // upper data bits are don't-care for the clamp register
    cfg_index <= CFG_MAX;
    cfg_wdata <= {3'($urandom_range(0, 7)), max_age};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned goal;
    int unsigned pick;
    logic [WORD_W-1:0] cap;
    goal = items_sent + n;
    while (items_sent < goal) begin
      steady = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      cap = pick_capacity();
      if (pick < 70) begin
        // clear, a few adds, then compute
        if ($urandom_range(0, 4) != 0)
          put_item(ACT_CLEAR, AGE_W'($urandom_range(0, 15)), rand40(), rand40());
        repeat ($urandom_range(1, 8))
          put_item(ACT_ADD, AGE_W'($urandom_range(0, 15)), words_for(cap), rand40());
        put_item(ACT_COMPUTE, AGE_W'($urandom_range(0, 15)), rand40(), cap);
        if (pick < 15)
          put_item(ACT_COMPUTE, AGE_W'($urandom_range(0, 15)), rand40(), pick_capacity());
      end else if (pick < 82) begin
        // merge of another table, one add per age
        if ($urandom_range(0, 1) != 0)
          put_item(ACT_CLEAR, AGE_W'($urandom_range(0, 15)), rand40(), rand40());
        for (int a = 0; a < NUM_AGES; a++)
          put_item(ACT_ADD, AGE_W'(a), words_for(cap) >> 3, rand40());
        put_item(ACT_COMPUTE, AGE_W'($urandom_range(0, 15)), rand40(), cap);
      end else begin
        // lone transaction of any kind, unused action included
        put_item(2'($urandom_range(0, 3)), AGE_W'($urandom_range(0, 15)), rand40(),
                 pick_capacity());
      end
    end
    steady = 1'b0;
  endtask

  task automatic run_phase(input logic [RATIO_W-1:0] ratio, input logic [THR_W-1:0] max_age,
                           input int unsigned n);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    set_config(ratio, max_age);
    run_random(n);
  endtask

  initial begin
    in_valid <= 1'b0;
    in_action <= ACT_CLEAR;
    in_age <= '0;
    in_word_count <= '0;
    in_survivor_capacity <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_RATIO;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases at reset settings
    // empty table: no age passes desired
    put_item(ACT_COMPUTE, '0, '0, '0);
    // age zero add is never summed
    put_item(ACT_ADD, '0, WORD_MAX, '0);
    put_item(ACT_COMPUTE, AGE_MAX, WORD_MAX, '0);
    put_item(ACT_ADD, AGE_W'(1), WORD_W'(1), WORD_MAX);
    put_item(ACT_COMPUTE, '0, '0, '0);
    // running total equal to desired does not pass
    put_item(ACT_COMPUTE, '0, '0, WORD_W'(2));
    put_item(ACT_ADD, AGE_MAX, WORD_MAX, '0);
    put_item(ACT_COMPUTE, '0, '0, WORD_MAX);
    put_item(ACT_ADD, AGE_W'(7), WORD_W'(5), '0);
    put_item(ACT_COMPUTE, '0, '0, WORD_W'(2));
    // unused action changes nothing
    put_item(ACT_UNUSED, AGE_MAX, WORD_MAX, WORD_MAX);
    put_item(ACT_COMPUTE, AGE_MAX, WORD_MAX, WORD_W'(13));
    put_item(ACT_CLEAR, AGE_MAX, WORD_MAX, WORD_MAX);
    put_item(ACT_COMPUTE, '0, '0, WORD_MAX);
    put_item(ACT_ADD, AGE_MAX, '0, '0);
    put_item(ACT_ADD, AGE_W'(3), WORD_MAX, '0);
    put_item(ACT_ADD, AGE_W'(3), WORD_MAX, '0);
    put_item(ACT_COMPUTE, '0, '0, WORD_MAX);
    put_item(ACT_UNUSED, '0, '0, '0);
    put_item(ACT_COMPUTE, '0, '0, '0);

    // zero ratio: first nonzero age from 1 wins
    run_phase(RATIO_W'(0), THR_W'(15), 250);

    // clamp to zero, with a full drain in the middle
    run_phase(RATIO_W'(100), THR_W'(0), 120);
    drain();
    run_random(110);

    // ratio above one hundred, then a saturating entry
    run_phase(RATIO_W'(127), THR_W'(7), 150);
    put_item(ACT_CLEAR, '0, rand40(), rand40());
    begin : sat_run
      logic [AGE_W-1:0] sat_age;
      sat_age = AGE_W'($urandom_range(1, 15));
      steady = 1'b1;
      repeat (270) put_item(ACT_ADD, sat_age, WORD_MAX, rand40());
      repeat (5) put_item(ACT_ADD, '0, WORD_MAX, rand40());
      put_item(ACT_COMPUTE, AGE_MAX, WORD_MAX, WORD_MAX);
      put_item(ACT_COMPUTE, '0, '0, rand40());
      steady = 1'b0;
    end
    run_random(50);

    run_phase(RATIO_W'(1), THR_W'(15), 200);

    // long result hold while the sender keeps offering
    run_phase(RATIO_W'($urandom_range(0, 127)), THR_W'($urandom_range(0, 15)), 100);
    hold_count <= hold_count + 1;
    run_random(60);
    run_random(150);

    run_phase(RATIO_W'(99), THR_W'(3), 150);

    // wind down
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[age_histogram_tenure_threshold.f]
design/ahtt_pkg.sv
design/ahtt_ram.sv
design/age_histogram_tenure_threshold.sv
verif/ahtt_tenure_checker.sv
verif/age_histogram_tenure_threshold_tb.sv
